>>> design/usd_pkg.sv
// Shared types, status codes and lead-byte helpers for the UTF-8 stream decoder.
// No dependencies.
`default_nettype none

package usd_pkg;

  localparam int unsigned CP_W    = 31;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned TOTAL_W = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_of_buffer;
  } usd_in_t;

  typedef struct packed {
    logic [CP_W-1:0]    codepoint;
    logic [LEN_W-1:0]   char_bytes;
    logic [TOTAL_W-1:0] char_total;
    status_t            status;
    logic               end_of_buffer;
  } usd_out_t;

  // Sequence length selected by a lead byte; zero marks an invalid lead.
  function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
    logic [LEN_W-1:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else if (b[7:2] == 6'b111110) begin
      len = 3'd5;
    end else if (b[7:1] == 7'b1111110) begin
      len = 3'd6;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // Payload bits carried by a lead byte of the given sequence length.
  function automatic logic [6:0] lead_payload(input logic [7:0] b, input logic [LEN_W-1:0] len);
    logic [6:0] p;
    case (len)
      3'd2:    p = {2'b00, b[4:0]};
      3'd3:    p = {3'b000, b[3:0]};
      3'd4:    p = {4'b0000, b[2:0]};
      3'd5:    p = {5'b00000, b[1:0]};
      3'd6:    p = {6'b000000, b[0]};
      default: p = b[6:0];
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> design/usd_core.sv
// Per-byte decode: sequence state, codepoint accumulator and character counter.
// Depends on usd_pkg.
`default_nettype none

module usd_core
  import usd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     advance,
  input  wire usd_in_t  item,
  output logic          res_valid,
  output usd_out_t      res
);

  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [LEN_W-1:0]   seq_r, seq_nxt;
  logic [CP_W-1:0]    acc_r, acc_nxt;
  logic [TOTAL_W-1:0] cnt_r, cnt_nxt;
  logic               disc_r, disc_nxt;
  status_t            pend_r, pend_nxt;

  logic [7:0]         b;
  logic               last;
  logic [LEN_W-1:0]   len;
  logic [CP_W-1:0]    acc_shift;
  logic [LEN_W-1:0]   rem_dec;
  logic [TOTAL_W-1:0] cnt_inc;

  // Fault handling shared by every fault path.
  logic               flt;
  status_t            flt_code;
  logic               done;
  logic [CP_W-1:0]    done_cp;
  logic [LEN_W-1:0]   done_len;

  assign b         = item.in_byte;
  assign last      = item.last_of_buffer;
  assign len       = lead_length(b);
  assign acc_shift = {acc_r[CP_W-7:0], b[5:0]};
  assign rem_dec   = rem_r - 3'd1;
  assign cnt_inc   = (cnt_r == {TOTAL_W{1'b1}}) ? cnt_r : cnt_r + 32'd1;

  always_comb begin
    flt      = 1'b0;
    flt_code = ST_OK;
    done     = 1'b0;
    done_cp  = '0;
    done_len = '0;
    rem_nxt  = rem_r;
    seq_nxt  = seq_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    disc_nxt = disc_r;
    pend_nxt = pend_r;
    res_valid = 1'b0;
    res       = '0;

    if (disc_r) begin
      if (last) begin
        res_valid = 1'b1;
        res.char_total    = cnt_r;
        res.status        = pend_r;
        res.end_of_buffer = 1'b1;
      end
    end else if (rem_r == 3'd0) begin
      if (len == 3'd0) begin
        flt      = 1'b1;
        flt_code = ST_INVALID;
      end else if (len == 3'd1) begin
        done     = 1'b1;
        done_cp  = {24'd0, b[6:0]};
        done_len = 3'd1;
      end else if (last) begin
        flt      = 1'b1;
        flt_code = ST_TRUNCATED;
      end else begin
        acc_nxt = {24'd0, lead_payload(b, len)};
        seq_nxt = len;
        rem_nxt = len - 3'd1;
      end
    end else if (b[7:6] != 2'b10) begin
      flt      = 1'b1;
      flt_code = ST_INVALID;
    end else if (rem_dec == 3'd0) begin
      done     = 1'b1;
      done_cp  = acc_shift;
      done_len = seq_r;
    end else if (last) begin
      flt      = 1'b1;
      flt_code = ST_TRUNCATED;
    end else begin
      acc_nxt = acc_shift;
      rem_nxt = rem_dec;
    end

    if (flt) begin
      rem_nxt = '0;
      seq_nxt = '0;
      acc_nxt = '0;
      if (last) begin
        res_valid = 1'b1;
        res.char_total    = cnt_r;
        res.status        = flt_code;
        res.end_of_buffer = 1'b1;
      end else begin
        disc_nxt = 1'b1;
        pend_nxt = flt_code;
      end
    end

    if (done) begin
      res_valid = 1'b1;
      res.codepoint     = done_cp;
      res.char_bytes    = done_len;
      res.char_total    = cnt_inc;
      res.status        = ST_OK;
      res.end_of_buffer = last;
      cnt_nxt = cnt_inc;
      rem_nxt = '0;
      seq_nxt = '0;
      acc_nxt = '0;
    end

    // drop all sequence state at the end of every buffer
    if (last) begin
      rem_nxt  = '0;
      seq_nxt  = '0;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      disc_nxt = 1'b0;
      pend_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      seq_r  <= '0;
      acc_r  <= '0;
      cnt_r  <= '0;
      disc_r <= 1'b0;
      pend_r <= ST_OK;
    end else if (advance) begin
      rem_r  <= rem_nxt;
      seq_r  <= seq_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      disc_r <= disc_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/usd_out_buf.sv
// Result register with a skid entry, so the decoder keeps moving while a result waits.
// Depends on usd_pkg.
`default_nettype none

module usd_out_buf
  import usd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_valid,
  input  wire usd_out_t wr_data,
  output logic          can_take,
  output logic          out_valid,
  input  wire logic     out_ready,
  output usd_out_t      out_data
);

  logic     main_valid_r, main_valid_nxt;
  usd_out_t main_data_r, main_data_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  usd_out_t skid_data_r, skid_data_nxt;
  logic     pop;

  assign can_take  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;
  assign pop       = main_valid_r && out_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    main_data_nxt  = main_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!main_valid_r || pop) begin
      // main slot frees up: refill from skid first to keep order
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = wr_valid;
        skid_data_nxt  = wr_data;
      end else begin
        main_valid_nxt = wr_valid;
        main_data_nxt  = wr_data;
      end
    end else if (wr_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

`default_nettype wire

>>> design/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: input register, decode core and result buffer.
// Depends on usd_pkg, usd_core and usd_out_buf.
`default_nettype none

// Accepts one byte per cycle while in_ready is high and returns at most one result
// per byte. The byte lands in the input register, and its result lands in the result
// register or its skid entry when the core consumes it.
// Lead bytes of 1 to 6 bytes are decoded, legacy forms included, with no overlong
// or surrogate checks. A fault is reported once, at the buffer's last byte, with
// codepoint and char_bytes zero; the bytes up to that point are dropped. The
// per-byte path is the lead classification plus a 6-bit shift into the codepoint
// accumulator and the saturating character count. in_ready drops only when both
// the result register and its skid entry hold results that are not taken.

module utf8_stream_decoder
  import usd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire usd_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output usd_out_t      out_data
);

  logic     in_valid_r, in_valid_nxt;
  usd_in_t  in_data_r;
  logic     can_take;
  logic     advance;
  logic     res_valid;
  usd_out_t res;

  assign advance  = in_valid_r && can_take;
  assign in_ready = !in_valid_r || can_take;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // hold the byte until the core consumes it
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  usd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (in_data_r),
    .res_valid (res_valid),
    .res       (res)
  );

  usd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_valid  (advance && res_valid),
    .wr_data   (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> tb/utf8_stream_decoder_tb.sv
// Self-checking testbench for utf8_stream_decoder: byte driver, result monitor and
// a byte-level decode predictor that tracks sequence, discard and count state.
// Depends on usd_pkg and the utf8_stream_decoder RTL.
`timescale 1ns / 100ps

module utf8_stream_decoder_tb;
  import usd_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned BYTES_PER_PHASE = 425;
  localparam int unsigned NUM_PHASES      = 4;
  localparam int unsigned HOLD_AT         = 60;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_CYCLES    = 10;

  // sender idle and receiver stall percentages per phase
  localparam int unsigned SEND_IDLE [NUM_PHASES]  = '{0, 82, 0, 8};
  localparam int unsigned RECV_STALL [NUM_PHASES] = '{0, 0, 82, 8};

  // {in_byte, last_of_buffer}
  localparam logic [8:0] DIRECTED_BYTES [24] = '{
    {8'h00, 1'b0}, {8'h7F, 1'b0}, {8'hDF, 1'b0}, {8'hBF, 1'b0},
    {8'hF7, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
    {8'hFD, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
    {8'hBF, 1'b0}, {8'hBF, 1'b1},
    {8'hFE, 1'b1},
    {8'h41, 1'b0}, {8'hFF, 1'b0}, {8'h41, 1'b0}, {8'hC2, 1'b1},
    {8'hC2, 1'b1},
    {8'hE0, 1'b0}, {8'h80, 1'b1},
    {8'hC2, 1'b0}, {8'h41, 1'b1}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  usd_in_t  in_data   = '0;
  logic     out_ready = 1'b0;
  logic     in_ready;
  logic     out_valid;
  usd_out_t out_data;

  usd_in_t  pending_bytes[$];
  usd_out_t expected_decodes[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_queued   = 0;
  int unsigned bytes_taken    = 0;
  int unsigned hold_left      = 0;
  logic        hold_done      = 1'b0;
  int unsigned cycle_count    = 0;
  int          mismatch_count = 0;

  // decoder state as predicted
  logic [2:0]  dec_remaining = '0;
  logic [2:0]  dec_length    = '0;
  logic [30:0] dec_acc       = '0;
  logic [31:0] dec_count     = '0;
  logic        dec_discard   = 1'b0;
  status_t     dec_pending   = ST_OK;

  utf8_stream_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction

  function automatic logic [2:0] seq_len_of(input logic [7:0] b);
    casez (b)
      8'b0???????: return 3'd1;
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      8'b111110??: return 3'd5;
      8'b1111110?: return 3'd6;
      default:     return 3'd0;
    endcase
  endfunction

  task automatic clear_decoder();
    dec_remaining = '0;
    dec_length    = '0;
    dec_acc       = '0;
    dec_count     = '0;
    dec_discard   = 1'b0;
    dec_pending   = ST_OK;
  endtask

  task automatic push_decode(input logic [30:0] cp, input logic [2:0] nbytes,
                             input status_t st, input logic eob);
    usd_out_t r;
    r.codepoint     = cp;
    r.char_bytes    = nbytes;
    r.char_total    = dec_count;
    r.status        = st;
    r.end_of_buffer = eob;
    expected_decodes.push_back(r);
  endtask

  // Report at once on the last byte, else drop bytes until the buffer ends.
  task automatic flag_fault(input status_t st, input logic last);
    if (last) begin
      push_decode('0, '0, st, 1'b1);
      clear_decoder();
    end else begin
      dec_discard   = 1'b1;
      dec_pending   = st;
      dec_remaining = '0;
      dec_length    = '0;
      dec_acc       = '0;
    end
  endtask

  task automatic finish_char(input logic [30:0] cp, input logic [2:0] nbytes,
                             input logic last);
    if (dec_count != '1) dec_count = dec_count + 1;
    push_decode(cp, nbytes, ST_OK, last);
    dec_remaining = '0;
    dec_length    = '0;
    dec_acc       = '0;
    if (last) clear_decoder();
  endtask

  task automatic decode_byte(input usd_in_t item);
    logic [7:0] b;
    logic       last;
    logic [2:0] len;
    b    = item.in_byte;
    last = item.last_of_buffer;
    if (dec_discard) begin
      if (last) begin
        push_decode('0, '0, dec_pending, 1'b1);
        clear_decoder();
      end
    end else if (dec_remaining == 0) begin
      len = seq_len_of(b);
      if (len == 0) begin
        flag_fault(ST_INVALID, last);
      end else if (len == 1) begin
        finish_char({24'd0, b[6:0]}, 3'd1, last);
      end else if (last) begin
        flag_fault(ST_TRUNCATED, 1'b1);
      end else begin
        dec_acc       = {23'd0, b & (8'hFF >> (int'(len) + 1))};
        dec_length    = len;
        dec_remaining = len - 3'd1;
      end
    end else if (b[7:6] != 2'b10) begin
      flag_fault(ST_INVALID, last);
    end else begin
      dec_acc       = {dec_acc[24:0], b[5:0]};
      dec_remaining = dec_remaining - 3'd1;
      if (dec_remaining == 0) begin
        finish_char(dec_acc, dec_length, last);
      end else if (last) begin
        flag_fault(ST_TRUNCATED, 1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus

  task automatic queue_byte(input logic [7:0] b, input logic last);
    usd_in_t item;
    item.in_byte        = b;
    item.last_of_buffer = last;
    pending_bytes.push_back(item);
    bytes_queued++;
  endtask

  // Queue the first count bytes of a len-byte sequence with random payload.
  task automatic queue_seq(input int unsigned len, input int unsigned count);
    logic [7:0] b;
    for (int unsigned i = 0; i < count; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i != 0) begin
        b = {2'b10, b[5:0]};
      end else if (len == 1) begin
        b[7] = 1'b0;
      end else begin
        b = ~(8'hFF >> len) | (b & (8'hFF >> (len + 1)));
      end
      queue_byte(b, 1'b0);
    end
  endtask

  task automatic queue_noise(input int unsigned count);
    repeat (count) queue_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic queue_random_buffer();
    int unsigned kind;
    int unsigned len;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      repeat ($urandom_range(1, 6)) begin
        len = $urandom_range(1, 6);
        queue_seq(len, len);
      end
    end else if (kind < 88) begin
      repeat ($urandom_range(0, 3)) begin
        len = $urandom_range(1, 6);
        queue_seq(len, len);
      end
      case ($urandom_range(0, 2))
        0: begin
          // truncated sequence at the end of the buffer
          len = $urandom_range(2, 6);
          queue_seq(len, $urandom_range(1, len - 1));
        end
        1: begin
          len = $urandom_range(2, 6);
          queue_seq(len, $urandom_range(1, len - 1));
          b = 8'($urandom_range(0, 255));
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          queue_byte(b, 1'b0);
          queue_noise($urandom_range(0, 4));
        end
        default: begin
          case ($urandom_range(0, 2))
            0:       b = 8'hFE;
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(8'h80, 8'hBF));
          endcase
          queue_byte(b, 1'b0);
          queue_noise($urandom_range(0, 4));
        end
      endcase
    end else begin
      queue_noise($urandom_range(1, 8));
    end
    pending_bytes[pending_bytes.size() - 1].last_of_buffer = 1'b1;
  endtask

  initial begin
    int unsigned target;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_BYTES[i]) queue_byte(DIRECTED_BYTES[i][8:1], DIRECTED_BYTES[i][0]);
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct  <= SEND_IDLE[p];
      recv_stall_pct <= RECV_STALL[p];
      target = bytes_queued + BYTES_PER_PHASE;
      while (bytes_queued < target) queue_random_buffer();
      while (pending_bytes.size() != 0 || in_valid || expected_decodes.size() != 0)
        @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("utf8_stream_decoder: match");
    end else begin
      $display("utf8_stream_decoder: mismatch");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Byte driver: predict on each accepted transaction, then offer the next byte.

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_data);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stalls, plus one long hold-off to back up the input.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken == HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    usd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_decodes.size() == 0) begin
        $display("%0t: result with none expected, got cp %0h bytes %0d total %0d st %0d eob %0b",
                 $time, out_data.codepoint, out_data.char_bytes, out_data.char_total,
                 out_data.status, out_data.end_of_buffer);
        mismatch_count++;
      end else begin
        want = expected_decodes.pop_front();
        compare_field("codepoint", 32'(want.codepoint), 32'(out_data.codepoint));
        compare_field("char_bytes", 32'(want.char_bytes), 32'(out_data.char_bytes));
        compare_field("char_total", want.char_total, out_data.char_total);
        compare_field("status", 32'(want.status), 32'(out_data.status));
        compare_field("end_of_buffer", 32'(want.end_of_buffer),
                      32'(out_data.end_of_buffer));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("utf8_stream_decoder: mismatch");
      $finish;
    end
  end

endmodule
